/* rtl/vdr_pkg.sv */
// Shared types and constants for the visibility disk reveal block.
package vdr_pkg;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REVEAL_RADIUS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_SIDE = 3'd4;

	localparam logic FUNC_POS = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	// One classified request handed from front to back.
	typedef struct packed {
		logic        func;
		logic [32:0] off_x;
		logic [32:0] off_y;
		logic [15:0] read_index;
	} vdr_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIVX,
		ST_DIVY,
		ST_DIVR,
		ST_CHECK,
		ST_PAINT,
		ST_RD_ISSUE,
		ST_RD_WAIT,
		ST_OUT
	} vdr_state_t;

endpackage

/* rtl/visibility_disk_reveal_top.sv */
// Top level of the visibility disk reveal block.
// After reset a clearing pass darkens the map, one cell per cycle; no request is served until
// it ends. A map read goes through an issue and a wait state to the result register. A position
// report runs three 33-step serial divisions (x cell, y cell, radius), then, when the cell is
// new, walks the (2r+1)^2 offsets around it, r the radius in cells, one offset per cycle, and
// writes the map where an offset lies inside the disk and on the map.
// A two-entry request queue lets new requests in while the back end works.
module visibility_disk_reveal_top #(
	parameter int MAP_MAX_SIDE = 256,
	parameter int MAX_RADIUS_CELLS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,  // pos_x[31:0], pos_y[63:32], read_index[79:64]
	input  logic        s_tuser,  // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // revealed[0], cell_x[33:1], cell_y[66:34], read_bit[67]
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [31:0] cfg_data
);
	logic signed [31:0] ox_q, oy_q;
	logic [15:0] cs_q;
	logic [19:0] rr_q;
	logic [8:0]  ms_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ox_q <= '0;
			oy_q <= '0;
			cs_q <= 16'd100;
			rr_q <= 20'd1000;
			ms_q <= 9'd256;
		end else if (cfg_we) begin
			case (cfg_idx)
				vdr_pkg::REG_ORIGIN_X: ox_q <= cfg_data;
				vdr_pkg::REG_ORIGIN_Y: oy_q <= cfg_data;
				vdr_pkg::REG_CELL_SIZE: cs_q <= cfg_data[15:0];
				vdr_pkg::REG_REVEAL_RADIUS: rr_q <= cfg_data[19:0];
				vdr_pkg::REG_MAP_SIDE: ms_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	logic q_valid, q_pop;
	vdr_pkg::vdr_req_t q_head;
	logic rev, rb;
	logic signed [32:0] cx, cy;

	vdr_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.func(s_tuser), .pos_x(s_tdata[31:0]), .pos_y(s_tdata[63:32]),
		.read_index(s_tdata[79:64]),
		.origin_x(ox_q), .origin_y(oy_q),
		.q_valid(q_valid), .q_pop(q_pop), .q_head(q_head)
	);

	vdr_back #(.MAP_MAX_SIDE(MAP_MAX_SIDE), .MAX_RADIUS_CELLS(MAX_RADIUS_CELLS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_pop(q_pop), .q_head(q_head),
		.cell_size(cs_q), .reveal_radius(rr_q), .map_side(ms_q),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.revealed(rev), .cell_x(cx), .cell_y(cy), .read_bit(rb)
	);

	assign m_tdata = {4'd0, rb, cy, cx, rev};
endmodule

/* rtl/vdr_front.sv */
// Front stage: accepts requests, forms origin offsets, holds a two-entry queue.
module vdr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                func,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	input  logic [15:0]         read_index,
	input  logic signed [31:0]  origin_x,
	input  logic signed [31:0]  origin_y,
	output logic                q_valid,
	input  logic                q_pop,
	output vdr_pkg::vdr_req_t   q_head
);
	vdr_pkg::vdr_req_t ent_q [2];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;
	vdr_pkg::vdr_req_t nreq;
	logic push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_head = ent_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = q_pop && q_valid;

	// Offset from origin, 33-bit signed.
	always_comb begin
		nreq.func = func;
		nreq.off_x = {pos_x[31], pos_x} - {origin_x[31], origin_x};
		nreq.off_y = {pos_y[31], pos_y} - {origin_y[31], origin_y};
		nreq.read_index = read_index;
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= nreq;
	end

	// Queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	ap_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue overflow");
	ap_full: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !in_ready) else $error("ready while full");
	ap_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 && !push) |=> cnt_q == 2'd0) else $error("count moved");
endmodule

/* rtl/vdr_back.sv */
// Back stage: divisions, disk painting, map memory with clearing pass, result register.
module vdr_back #(
	parameter int MAP_MAX_SIDE = 256,
	parameter int MAX_RADIUS_CELLS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	output logic                q_pop,
	input  vdr_pkg::vdr_req_t   q_head,
	input  logic [15:0]         cell_size,
	input  logic [19:0]         reveal_radius,
	input  logic [8:0]          map_side,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                revealed,
	output logic signed [32:0]  cell_x,
	output logic signed [32:0]  cell_y,
	output logic                read_bit
);
	localparam int SW = $clog2(MAP_MAX_SIDE + 1);
	localparam int AW = 2 * $clog2(MAP_MAX_SIDE);
	localparam int DEPTH = MAP_MAX_SIDE * MAP_MAX_SIDE;
	localparam int RW = $clog2(MAX_RADIUS_CELLS + 1);
	localparam int OW = RW + 1;

	vdr_pkg::vdr_state_t st_q, st_d;

	logic mem [DEPTH];
	logic rd_s1;

	logic [AW:0]  clr_q;
	logic         clr_busy;
	assign clr_busy = !clr_q[AW];

	// Divider registers: 33-bit magnitude long division, one bit per cycle
	logic [32:0] rem_q, quo_q;
	logic [5:0]  dcnt_q;
	logic        neg_q;
	logic signed [32:0] cx_q, cy_q, lastx_q, lasty_q;
	logic        lastv_q;
	logic [RW-1:0] r_q;
	logic signed [OW-1:0] dx_q, dy_q;
	logic [SW-1:0] side_q;
	logic        fresh;
	logic [15:0] cs;
	logic [SW-1:0] side_c;

	logic        ov_q, orev_q, obit_q;
	logic signed [32:0] ocx_q, ocy_q;

	assign cs = (cell_size == 16'd0) ? 16'd1 : cell_size;
	always_comb begin
		if (map_side == 9'd0) side_c = SW'(1);
		else if (32'(map_side) > MAP_MAX_SIDE) side_c = SW'(MAP_MAX_SIDE);
		else side_c = SW'(map_side);
	end

	// Divider step
	logic [33:0] trial;
	logic [32:0] rem_sh;
	logic [32:0] num_abs;
	logic [32:0] dnum;
	assign rem_sh = {rem_q[31:0], quo_q[32]};
	assign trial = {1'b0, rem_sh} - {18'd0, cs};

	// Disk test on the current offset
	logic signed [2*OW-1:0] dsq;
	logic [2*RW-1:0] rsq;
	logic signed [34:0] tx, ty;
	logic inb, indisk, last_pt;
	logic [AW-1:0] waddr;
	assign dsq = dx_q * dx_q + dy_q * dy_q;
	assign rsq = r_q * r_q;
	assign indisk = dsq <= $signed({1'b0, rsq});
	assign tx = 35'(cy_q) + 35'(dy_q);
	assign ty = 35'(side_q) - 35'sd1 - 35'(cx_q) - 35'(dx_q);
	assign inb = !tx[34] && !ty[34] && tx < 35'(side_q) && ty < 35'(side_q);
	assign waddr = AW'(ty[AW-1:0] * side_q + tx[AW-1:0]);
	assign last_pt = (dx_q == $signed(OW'(r_q))) && (dy_q == $signed(OW'(r_q)));

	logic [31:0] sq;
	assign sq = 32'(side_c) * 32'(side_c);

	// Memory: clearing pass, paint writes, registered read
	always_ff @(posedge clk) begin
		if (clr_busy) mem[clr_q[AW-1:0]] <= 1'b0;
		else if (st_q == vdr_pkg::ST_PAINT && indisk && inb) mem[waddr] <= 1'b1;
		rd_s1 <= mem[AW'(q_head.read_index)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= vdr_pkg::ST_IDLE;
		else st_q <= st_d;
	end

	always_comb begin
		st_d = st_q;
		q_pop = 1'b0;
		case (st_q)
			vdr_pkg::ST_IDLE: begin
				if (q_valid && !clr_busy && !ov_q)
					st_d = (q_head.func == vdr_pkg::FUNC_READ) ? vdr_pkg::ST_RD_ISSUE
						: vdr_pkg::ST_DIVX;
			end
			vdr_pkg::ST_DIVX: if (dcnt_q == 6'd33) st_d = vdr_pkg::ST_DIVY;
			vdr_pkg::ST_DIVY: if (dcnt_q == 6'd33) st_d = vdr_pkg::ST_DIVR;
			vdr_pkg::ST_DIVR: if (dcnt_q == 6'd33) st_d = vdr_pkg::ST_CHECK;
			vdr_pkg::ST_CHECK: st_d = fresh ? vdr_pkg::ST_PAINT : vdr_pkg::ST_OUT;
			vdr_pkg::ST_PAINT: if (last_pt) st_d = vdr_pkg::ST_OUT;
			vdr_pkg::ST_RD_ISSUE: st_d = vdr_pkg::ST_RD_WAIT;
			vdr_pkg::ST_RD_WAIT: st_d = vdr_pkg::ST_OUT;
			vdr_pkg::ST_OUT: begin
				q_pop = 1'b1;
				st_d = vdr_pkg::ST_IDLE;
			end
			default: st_d = vdr_pkg::ST_IDLE;
		endcase
	end

	// Datapath
	always_comb begin
		case (st_q)
			vdr_pkg::ST_IDLE: dnum = q_head.off_x;
			vdr_pkg::ST_DIVX: dnum = q_head.off_y;
			default: dnum = {13'd0, reveal_radius};
		endcase
		num_abs = dnum[32] ? (33'd0 - dnum) : dnum;
	end

	logic [32:0] qfin;
	logic        rfin_nz;
	logic signed [32:0] sres;
	assign qfin = quo_q;
	assign rfin_nz = rem_q != 33'd0;
	assign sres = neg_q ? ($signed(33'd0 - qfin) - (rfin_nz ? 33'sd1 : 33'sd0))
		: $signed(qfin);

	always_ff @(posedge clk) begin
		case (st_q)
			vdr_pkg::ST_IDLE: begin
				rem_q <= 33'd0;
				quo_q <= num_abs;
				neg_q <= dnum[32];
				dcnt_q <= 6'd0;
				side_q <= side_c;
			end
			vdr_pkg::ST_DIVX, vdr_pkg::ST_DIVY, vdr_pkg::ST_DIVR: begin
				if (dcnt_q == 6'd33) begin
					if (st_q == vdr_pkg::ST_DIVX) cx_q <= sres;
					else if (st_q == vdr_pkg::ST_DIVY) cy_q <= sres;
					else begin
						if (qfin + {32'd0, rfin_nz} > 33'(MAX_RADIUS_CELLS))
							r_q <= RW'(MAX_RADIUS_CELLS);
						else r_q <= RW'(qfin + {32'd0, rfin_nz});
					end
					rem_q <= 33'd0;
					quo_q <= num_abs;
					neg_q <= dnum[32];
					dcnt_q <= 6'd0;
				end else begin
					dcnt_q <= dcnt_q + 6'd1;
					if (!trial[33]) begin
						rem_q <= trial[32:0];
						quo_q <= {quo_q[31:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[31:0], 1'b0};
					end
				end
			end
			vdr_pkg::ST_CHECK: begin
				dx_q <= -$signed(OW'(r_q));
				dy_q <= -$signed(OW'(r_q));
			end
			vdr_pkg::ST_PAINT: begin
				if (dx_q == $signed(OW'(r_q))) begin
					dx_q <= -$signed(OW'(r_q));
					dy_q <= dy_q + OW'(1);
				end else dx_q <= dx_q + OW'(1);
			end
			default: ;
		endcase
	end

	always_comb fresh = !lastv_q || cx_q != lastx_q || cy_q != lasty_q;

	// Control registers: last cell, clearing counter, result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lastv_q <= 1'b0;
			lastx_q <= '0;
			lasty_q <= '0;
			clr_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (clr_busy) clr_q <= clr_q + 1'b1;
			if (st_q == vdr_pkg::ST_CHECK && fresh) begin
				lastv_q <= 1'b1;
				lastx_q <= cx_q;
				lasty_q <= cy_q;
			end
			if (st_q == vdr_pkg::ST_OUT) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	logic fr_s1;
	always_ff @(posedge clk) begin
		if (st_q == vdr_pkg::ST_CHECK) fr_s1 <= fresh;
		if (st_q == vdr_pkg::ST_OUT) begin
			if (q_head.func == vdr_pkg::FUNC_READ) begin
				orev_q <= 1'b0;
				ocx_q <= '0;
				ocy_q <= '0;
				obit_q <= obit_q;
			end else begin
				orev_q <= fr_s1;
				ocx_q <= cx_q;
				ocy_q <= cy_q;
				obit_q <= 1'b0;
			end
		end else if (st_q == vdr_pkg::ST_RD_WAIT) begin
			obit_q <= (32'(q_head.read_index) < sq) ? rd_s1 : 1'b0;
		end
	end

	assign out_valid = ov_q;
	assign revealed = orev_q;
	assign cell_x = ocx_q;
	assign cell_y = ocy_q;
	assign read_bit = obit_q;

	ap_paint: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == vdr_pkg::ST_PAINT |-> !clr_busy) else $error("paint during clear");
	ap_out: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == vdr_pkg::ST_OUT |-> !ov_q) else $error("result overwritten");
	ap_pop: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop from empty queue");
endmodule

/* tb/testbench.sv */
// Self-checking testbench for the visibility disk reveal block: stream driver and monitor.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic        func;
		logic [31:0] px;
		logic [31:0] py;
		logic [15:0] ridx;
	} vis_req_t;

	typedef struct {
		logic        revealed;
		logic [32:0] gx;
		logic [32:0] gy;
		logic        rbit;
	} vis_res_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [31:0] cfg_data;

	visibility_disk_reveal_top uut (.*);

	// predictor state
	logic     fog_map [0:65535];
	longint   org_x, org_y, last_gx, last_gy;
	int       cell_sz, rad_units, side_reg;
	bit       have_last;

	vis_req_t pending_reqs[$];
	vis_res_t expected_results[$];
	int       errors;
	int       idle_pct, stall_pct;
	bit       s_took;
	logic [31:0] prev_px, prev_py;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic longint sx32(logic [31:0] v);
		return longint'(signed'(v));
	endfunction

	function automatic longint div_floor(longint a, longint d);
		longint q;
		q = a / d;
		if ((a % d) != 0 && a < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic longint side_eff();
		if (side_reg == 0)
			return 1;
		if (side_reg > 256)
			return 256;
		return side_reg;
	endfunction

	function automatic longint cs_eff();
		return (cell_sz == 0) ? 1 : cell_sz;
	endfunction

	// compute the expected result of one accepted request and update the map
	task automatic reveal_predict(vis_req_t rq);
		vis_res_t res;
		longint   gx, gy, r, side, tx, ty, dx, dy, cs;
		res = '{1'b0, 33'd0, 33'd0, 1'b0};
		side = side_eff();
		if (rq.func == vdr_pkg::FUNC_READ) begin
			if (longint'(rq.ridx) < side * side)
				res.rbit = fog_map[rq.ridx];
		end else begin
			cs = cs_eff();
			gx = div_floor(sx32(rq.px) - org_x, cs);
			gy = div_floor(sx32(rq.py) - org_y, cs);
			if (!have_last || gx != last_gx || gy != last_gy) begin
				have_last = 1'b1;
				last_gx = gx;
				last_gy = gy;
				res.revealed = 1'b1;
				r = rad_units / cs + (((rad_units % cs) != 0) ? 1 : 0);
				if (r > 32)
					r = 32;
				for (dy = -r; dy <= r; dy++)
					for (dx = -r; dx <= r; dx++) begin
						tx = gy + dy;
						ty = side - 1 - (gx + dx);
						if (dx * dx + dy * dy <= r * r && tx >= 0 && ty >= 0 &&
							tx < side && ty < side)
							fog_map[ty * side + tx] = 1'b1;
					end
			end
			res.gx = gx[32:0];
			res.gy = gy[32:0];
		end
		expected_results.push_back(res);
	endtask

	task automatic push_req(logic func, logic [31:0] px, logic [31:0] py, logic [15:0] ridx);
		vis_req_t rq;
		rq = '{func, px, py, ridx};
		pending_reqs.push_back(rq);
		if (func == vdr_pkg::FUNC_POS) begin
			prev_px = px;
			prev_py = py;
		end
	endtask

	// mostly positions landing on or near the map, some repeats, reads and wild values
	task automatic add_random(int n);
		int      k, sel;
		longint  c, s, cs, vx, vy;
		for (k = 0; k < n; k++) begin
			sel = $urandom_range(99);
			s = side_eff();
			cs = cs_eff();
			if (sel < 50) begin
				c = longint'($urandom_range(s + 3)) - 2;
				vx = org_x + c * cs + longint'($urandom_range(cs - 1));
				c = longint'($urandom_range(s + 3)) - 2;
				vy = org_y + c * cs + longint'($urandom_range(cs - 1));
				push_req(vdr_pkg::FUNC_POS, vx[31:0], vy[31:0], 16'($urandom));
			end else if (sel < 60) begin
				push_req(vdr_pkg::FUNC_POS, prev_px, prev_py, 16'($urandom));
			end else if (sel < 70) begin
				push_req(vdr_pkg::FUNC_POS, $urandom, $urandom, 16'($urandom));
			end else if (sel < 88) begin
				push_req(vdr_pkg::FUNC_READ, $urandom, $urandom,
					16'($urandom_range(s * s - 1)));
			end else begin
				push_req(vdr_pkg::FUNC_READ, $urandom, $urandom, 16'($urandom));
			end
		end
	endtask

	task automatic wait_drained();
		wait (pending_reqs.size() == 0 && !s_tvalid && expected_results.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	// register write at a falling edge; set_regs fills unused upper data bits with random junk
	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		case (idx)
			vdr_pkg::REG_ORIGIN_X: org_x = sx32(val);
			vdr_pkg::REG_ORIGIN_Y: org_y = sx32(val);
			vdr_pkg::REG_CELL_SIZE: cell_sz = int'(val[15:0]);
			vdr_pkg::REG_REVEAL_RADIUS: rad_units = int'(val[19:0]);
			vdr_pkg::REG_MAP_SIDE: side_reg = int'(val[8:0]);
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_regs(longint ox, longint oy, int cs, int rad, int sd);
		write_reg(vdr_pkg::REG_ORIGIN_X, ox[31:0]);
		write_reg(vdr_pkg::REG_ORIGIN_Y, oy[31:0]);
		write_reg(vdr_pkg::REG_CELL_SIZE, {16'($urandom_range(65535)), 16'(cs)});
		write_reg(vdr_pkg::REG_REVEAL_RADIUS, {12'($urandom), 20'(rad)});
		write_reg(vdr_pkg::REG_MAP_SIDE, {23'($urandom), 9'(sd)});
	endtask

	// request driver
	always @(negedge clk) begin
		vis_req_t rq;
		m_tready <= ($urandom_range(99) >= stall_pct);
		if (!s_tvalid || s_took) begin
			if (arst_n && pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
				rq = pending_reqs.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= rq.func;
				s_tdata <= {rq.ridx, rq.py, rq.px};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		s_took = 1'b0;
	end

	// accept monitor and result checker
	always @(posedge clk) begin
		vis_req_t rq;
		vis_res_t ex;
		if (s_tvalid && s_tready) begin
			rq = '{s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[79:64]};
			reveal_predict(rq);
			s_took = 1'b1;
		end
		if (m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result %h", $realtime, m_tdata);
				errors++;
			end else begin
				ex = expected_results.pop_front();
				if (m_tdata[0] !== ex.revealed || m_tdata[33:1] !== ex.gx ||
					m_tdata[66:34] !== ex.gy || m_tdata[67] !== ex.rbit) begin
					$display("%0t: mismatch expected rev=%b x=%h y=%h bit=%b actual rev=%b x=%h y=%h bit=%b",
						$realtime, ex.revealed, ex.gx, ex.gy, ex.rbit,
						m_tdata[0], m_tdata[33:1], m_tdata[66:34], m_tdata[67]);
					errors++;
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("[visibility_disk_reveal_top] ERROR");
		$finish;
	end

	initial begin
		int k;
		for (k = 0; k < 65536; k++)
			fog_map[k] = 1'b0;
		org_x = 0; org_y = 0; cell_sz = 100; rad_units = 1000; side_reg = 256;
		have_last = 1'b0; last_gx = 0; last_gy = 0;
		errors = 0; idle_pct = 0; stall_pct = 0; s_took = 1'b0;
		prev_px = '0; prev_py = '0;
		arst_n = 1'b0;
		s_tvalid = 1'b0; s_tuser = 1'b0; s_tdata = '0; m_tready = 1'b0;
		cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: defaults, first position, same cell, edges, extremes, reads
		push_req(vdr_pkg::FUNC_READ, '0, '0, 16'd0);
		push_req(vdr_pkg::FUNC_POS, 32'd0, 32'd0, '0);
		push_req(vdr_pkg::FUNC_POS, 32'd99, 32'd99, 16'hFFFF);
		push_req(vdr_pkg::FUNC_POS, 32'd0, 32'd0, '0);
		push_req(vdr_pkg::FUNC_READ, '0, '0, 16'd65535);
		push_req(vdr_pkg::FUNC_READ, '0, '0, 16'd65280);
		push_req(vdr_pkg::FUNC_POS, 32'd25599, 32'd25599, '0);
		push_req(vdr_pkg::FUNC_POS, -32'sd1, -32'sd101, '0);
		push_req(vdr_pkg::FUNC_POS, 32'h8000_0000, 32'h7FFF_FFFF, '0);
		push_req(vdr_pkg::FUNC_POS, 32'h7FFF_FFFF, 32'h8000_0000, '0);
		push_req(vdr_pkg::FUNC_POS, 32'd12800, 32'd12800, '0);
		push_req(vdr_pkg::FUNC_READ, '0, '0, 16'd32896);
		push_req(vdr_pkg::FUNC_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd255);
		add_random(15);
		wait_drained();

		// small map, offset origin, no idling; unused register index too
		write_reg(3'd6, $urandom);
		set_regs(-1000, 2500, 50, 120, 64);
		push_req(vdr_pkg::FUNC_READ, '0, '0, 16'd4096);
		add_random(20);
		wait_drained();

		// extreme origins, widest cells, zero radius, one-cell map
		idle_pct = 82;
		set_regs(-64'sd2147483648, 64'sd2147483647, 65535, 0, 1);
		push_req(vdr_pkg::FUNC_POS, 32'h7FFF_FFFF, 32'h8000_0000, '0);
		push_req(vdr_pkg::FUNC_POS, 32'h8000_0000, 32'h7FFF_FFFF, '0);
		push_req(vdr_pkg::FUNC_READ, '0, '0, 16'd1);
		add_random(18);
		wait_drained();

		// unit cells, radius saturated at the bound: few, slow requests
		idle_pct = 0; stall_pct = 82;
		set_regs(0, 0, 1, 1048575, 256);
		push_req(vdr_pkg::FUNC_POS, 32'd128, 32'd128, '0);
		push_req(vdr_pkg::FUNC_POS, 32'd0, 32'd255, '0);
		add_random(6);
		wait_drained();

		// zero cell size, oversized map side
		idle_pct = 12; stall_pct = 12;
		set_regs(300, -300, 0, 2, 511);
		add_random(20);
		wait_drained();

		// zero map side, then a mid setting
		idle_pct = 82; stall_pct = 82;
		set_regs(7, 7, 3, 5, 0);
		add_random(8);
		wait_drained();
		idle_pct = 0; stall_pct = 0;
		set_regs(-77, 1234, 7, 20, 32);
		add_random(20);
		wait_drained();

		repeat (200) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("[visibility_disk_reveal_top] OK");
		else
			$display("[visibility_disk_reveal_top] ERROR");
		$finish;
	end
endmodule
